/* rtl/ets_pkg.sv */
package ets_pkg;

  localparam int POS_BITS = 16;
  localparam int QUEUE_DEPTH = 4;
  localparam int COUNT_BITS = $clog2(QUEUE_DEPTH + 1);
  localparam int PTR_BITS = $clog2(QUEUE_DEPTH);

  localparam logic OPC_CHAR = 1'b0;
  localparam logic OPC_END = 1'b1;

  localparam logic [15:0] SPAN_MAX = 16'hFFFF;

  typedef enum logic [4:0] {
    K_END        = 5'd0,
    K_NUMBER     = 5'd1,
    K_IDENT      = 5'd2,
    K_STRING     = 5'd3,
    K_TRUE       = 5'd4,
    K_FALSE      = 5'd5,
    K_ASSIGN     = 5'd6,
    K_EQUAL      = 5'd7,
    K_NOT        = 5'd8,
    K_NOTEQ      = 5'd9,
    K_GT         = 5'd10,
    K_GTEQ       = 5'd11,
    K_LT         = 5'd12,
    K_LTEQ       = 5'd13,
    K_AND        = 5'd14,
    K_OR         = 5'd15,
    K_PLUS       = 5'd16,
    K_MINUS      = 5'd17,
    K_ASTER      = 5'd18,
    K_DBL_ASTER  = 5'd19,
    K_SLASH      = 5'd20,
    K_DBL_SLASH  = 5'd21,
    K_MOD        = 5'd22,
    K_UNDERSCORE = 5'd23,
    K_LPAREN     = 5'd24,
    K_RPAREN     = 5'd25,
    K_BADCHAR    = 5'd26,
    K_UNTERM     = 5'd27
  } kind_t;

  typedef enum logic [2:0] {
    M_IDLE,
    M_NUMBER,
    M_IDENT,
    M_STRING,
    M_OP
  } scan_mode_t;

  typedef enum logic [2:0] {
    P_NONE,
    P_EQ,
    P_BANG,
    P_GT,
    P_LT,
    P_STAR,
    P_SLASH,
    P_MINUS
  } pend_t;

  localparam logic [3:0] KP_NONE = 4'd0;
  localparam logic [3:0] KP_T = 4'd1;
  localparam logic [3:0] KP_TRUE = 4'd4;
  localparam logic [3:0] KP_F = 4'd5;
  localparam logic [3:0] KP_FALSE = 4'd9;

  typedef struct packed {
    logic       opcode;
    logic [7:0] ch;
  } in_item_t;

  typedef struct packed {
    logic [4:0]  kind;
    logic [15:0] start_res;
    logic [15:0] span;
    logic        negative;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [1:0] n;
    out_item_t  r0;
    out_item_t  r1;
  } push_t;

  function automatic logic is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic [7:0] kw_char(logic [3:0] p);
    logic [7:0] c;
    case (p)
      4'd1: c = "r";
      4'd2: c = "u";
      4'd3: c = "e";
      4'd5: c = "a";
      4'd6: c = "l";
      4'd7: c = "s";
      4'd8: c = "e";
      default: c = 8'd0;
    endcase
    return c;
  endfunction

  function automatic kind_t single_kind(pend_t p);
    kind_t k;
    case (p)
      P_EQ: k = K_ASSIGN;
      P_BANG: k = K_NOT;
      P_GT: k = K_GT;
      P_LT: k = K_LT;
      P_STAR: k = K_ASTER;
      P_SLASH: k = K_SLASH;
      default: k = K_MINUS;
    endcase
    return k;
  endfunction

  function automatic kind_t ident_kind(logic [3:0] kp);
    kind_t k;
    if (kp == KP_TRUE) begin
      k = K_TRUE;
    end else if (kp == KP_FALSE) begin
      k = K_FALSE;
    end else begin
      k = K_IDENT;
    end
    return k;
  endfunction

  function automatic out_item_t mk_res(kind_t k, logic [POS_BITS-1:0] start,
                                       logic [15:0] span, logic neg);
    out_item_t r;
    r.kind = k;
    r.start_res = 16'(start);
    r.span = span;
    r.negative = neg;
    r.last = 1'b0;
    return r;
  endfunction

endpackage

/* rtl/ets_scan.sv */
module ets_scan (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_fire,
  input  ets_pkg::in_item_t in_item,
  output ets_pkg::push_t   push
);
  import ets_pkg::*;

  logic                s_vld_r;
  in_item_t            s_item_r;
  scan_mode_t          mode_r, mode_nxt;
  pend_t               pend_r, pend_nxt;
  logic [POS_BITS-1:0] pos_r, pos_nxt;
  logic [POS_BITS-1:0] tstart_r, tstart_nxt;
  logic [3:0]          kp_r, kp_nxt;
  logic                minus_r, minus_nxt;
  logic                halt_r, halt_nxt;
  logic [15:0]         tlen_r, tlen_nxt;

  logic      f_vld, e_vld, do_start;
  out_item_t f_item, e_item;
  logic [7:0] c;
  kind_t     two, k1;
  pend_t     p1;

  always_comb begin
    mode_nxt = mode_r;
    pend_nxt = pend_r;
    pos_nxt = pos_r;
    tstart_nxt = tstart_r;
    kp_nxt = kp_r;
    minus_nxt = minus_r;
    halt_nxt = halt_r;
    tlen_nxt = tlen_r;
    f_vld = 1'b0;
    e_vld = 1'b0;
    f_item = '0;
    e_item = '0;
    do_start = 1'b0;
    c = s_item_r.ch;
    two = K_END;
    k1 = K_END;
    p1 = P_NONE;
    if (s_vld_r) begin
      if (s_item_r.opcode == OPC_END) begin
        if (!halt_r) begin
          case (mode_r)
            M_NUMBER: begin
              f_vld = 1'b1;
              f_item = mk_res(K_NUMBER, tstart_r, tlen_r, minus_r);
            end
            M_IDENT: begin
              f_vld = 1'b1;
              f_item = mk_res(ident_kind(kp_r), tstart_r, tlen_r, 1'b0);
            end
            M_STRING: begin
              f_vld = 1'b1;
              f_item = mk_res(K_UNTERM, tstart_r, tlen_r, 1'b0);
            end
            M_OP: begin
              f_vld = 1'b1;
              f_item = mk_res(single_kind(pend_r), tstart_r, 16'd1, 1'b0);
            end
            default: begin
            end
          endcase
        end
        e_vld = 1'b1;
        e_item = mk_res(K_END, pos_r, 16'd0, 1'b0);
        mode_nxt = M_IDLE;
        pend_nxt = P_NONE;
        pos_nxt = '0;
        tstart_nxt = '0;
        kp_nxt = KP_NONE;
        minus_nxt = 1'b0;
        halt_nxt = 1'b0;
        tlen_nxt = '0;
      end else if (!halt_r) begin
        pos_nxt = pos_r + 1'b1;
        case (mode_r)
          M_NUMBER: begin
            if (is_digit(c) || c == ".") begin
              tlen_nxt = (tlen_r == SPAN_MAX) ? tlen_r : tlen_r + 16'd1;
            end else begin
              f_vld = 1'b1;
              f_item = mk_res(K_NUMBER, tstart_r, tlen_r, minus_r);
              do_start = 1'b1;
            end
          end
          M_IDENT: begin
            if ((kp_r == KP_TRUE || kp_r == KP_FALSE) && !(is_digit(c) || is_alpha(c))) begin
              f_vld = 1'b1;
              f_item = mk_res(ident_kind(kp_r), tstart_r, tlen_r, 1'b0);
              do_start = 1'b1;
            end else if (is_digit(c) || is_alpha(c) || c == "_") begin
              tlen_nxt = (tlen_r == SPAN_MAX) ? tlen_r : tlen_r + 16'd1;
              if (((kp_r >= 4'd1 && kp_r <= 4'd3) || (kp_r >= 4'd5 && kp_r <= 4'd8))
                  && c == kw_char(kp_r)) begin
                kp_nxt = kp_r + 4'd1;
              end else begin
                kp_nxt = KP_NONE;
              end
            end else begin
              f_vld = 1'b1;
              f_item = mk_res(ident_kind(kp_r), tstart_r, tlen_r, 1'b0);
              do_start = 1'b1;
            end
          end
          M_STRING: begin
            if (c == "\"") begin
              f_vld = 1'b1;
              f_item = mk_res(K_STRING, tstart_r, tlen_r, 1'b0);
              mode_nxt = M_IDLE;
              pend_nxt = P_NONE;
              kp_nxt = KP_NONE;
              minus_nxt = 1'b0;
              tlen_nxt = '0;
            end else begin
              tlen_nxt = (tlen_r == SPAN_MAX) ? tlen_r : tlen_r + 16'd1;
            end
          end
          M_OP: begin
            if (pend_r == P_MINUS && is_digit(c)) begin
              mode_nxt = M_NUMBER;
              pend_nxt = P_NONE;
              tstart_nxt = pos_r;
              tlen_nxt = 16'd1;
              minus_nxt = 1'b1;
            end else begin
              if (c == "=") begin
                case (pend_r)
                  P_EQ: two = K_EQUAL;
                  P_BANG: two = K_NOTEQ;
                  P_GT: two = K_GTEQ;
                  P_LT: two = K_LTEQ;
                  default: two = K_END;
                endcase
              end else if (c == "*" && pend_r == P_STAR) begin
                two = K_DBL_ASTER;
              end else if (c == "/" && pend_r == P_SLASH) begin
                two = K_DBL_SLASH;
              end
              f_vld = 1'b1;
              if (two != K_END) begin
                f_item = mk_res(two, tstart_r, 16'd2, 1'b0);
                mode_nxt = M_IDLE;
                pend_nxt = P_NONE;
                kp_nxt = KP_NONE;
                minus_nxt = 1'b0;
                tlen_nxt = '0;
              end else begin
                f_item = mk_res(single_kind(pend_r), tstart_r, 16'd1, 1'b0);
                do_start = 1'b1;
              end
            end
          end
          default: begin
            do_start = 1'b1;
          end
        endcase

        if (do_start) begin
          // return to idle, then let this character open a new token
          mode_nxt = M_IDLE;
          pend_nxt = P_NONE;
          kp_nxt = KP_NONE;
          minus_nxt = 1'b0;
          tlen_nxt = '0;
          if (is_space(c)) begin
          end else if (is_digit(c)) begin
            mode_nxt = M_NUMBER;
            tstart_nxt = pos_r;
            tlen_nxt = 16'd1;
          end else if (is_alpha(c)) begin
            mode_nxt = M_IDENT;
            tstart_nxt = pos_r;
            tlen_nxt = 16'd1;
            kp_nxt = (c == "t") ? KP_T : ((c == "f") ? KP_F : KP_NONE);
          end else if (c == "\"") begin
            mode_nxt = M_STRING;
            tstart_nxt = pos_r + 1'b1;
          end else begin
            case (c)
              "=": p1 = P_EQ;
              "!": p1 = P_BANG;
              ">": p1 = P_GT;
              "<": p1 = P_LT;
              "*": p1 = P_STAR;
              "/": p1 = P_SLASH;
              "-": p1 = P_MINUS;
              "&": k1 = K_AND;
              "|": k1 = K_OR;
              "_": k1 = K_UNDERSCORE;
              "+": k1 = K_PLUS;
              "%": k1 = K_MOD;
              "(": k1 = K_LPAREN;
              ")": k1 = K_RPAREN;
              default: k1 = K_BADCHAR;
            endcase
            if (p1 != P_NONE) begin
              mode_nxt = M_OP;
              pend_nxt = p1;
              tstart_nxt = pos_r;
            end else begin
              e_vld = 1'b1;
              e_item = mk_res(k1, pos_r, 16'd1, 1'b0);
              if (k1 == K_BADCHAR) begin
                halt_nxt = 1'b1;
              end
            end
          end
        end
      end
    end
  end

  // pack results into queue slots, last on the final one
  always_comb begin
    push = '0;
    if (f_vld) begin
      push.r0 = f_item;
      push.r1 = e_item;
      push.r0.last = !e_vld;
      push.r1.last = e_vld;
      push.n = e_vld ? 2'd2 : 2'd1;
    end else begin
      push.r0 = e_item;
      push.r0.last = e_vld;
      push.r1 = '0;
      push.n = e_vld ? 2'd1 : 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_vld_r <= 1'b0;
      mode_r <= M_IDLE;
      pend_r <= P_NONE;
      pos_r <= '0;
      tstart_r <= '0;
      kp_r <= KP_NONE;
      minus_r <= 1'b0;
      halt_r <= 1'b0;
      tlen_r <= '0;
    end else begin
      s_vld_r <= in_fire;
      mode_r <= mode_nxt;
      pend_r <= pend_nxt;
      pos_r <= pos_nxt;
      tstart_r <= tstart_nxt;
      kp_r <= kp_nxt;
      minus_r <= minus_nxt;
      halt_r <= halt_nxt;
      tlen_r <= tlen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s_item_r <= in_item;
    end
  end

endmodule

/* rtl/ets_queue.sv */
module ets_queue (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ets_pkg::push_t                push,
  input  logic                          pop,
  output logic                          rd_vld,
  output ets_pkg::out_item_t            rd_item,
  output logic [ets_pkg::COUNT_BITS-1:0] count
);
  import ets_pkg::*;

  out_item_t             q_r [QUEUE_DEPTH];
  logic [PTR_BITS-1:0]   wr_r, wr_nxt;
  logic [PTR_BITS-1:0]   rd_r, rd_nxt;
  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt;
  logic [PTR_BITS-1:0]   wr1;

  assign wr1 = wr_r + 1'b1;
  assign rd_vld = cnt_r != '0;
  assign rd_item = q_r[rd_r];
  assign count = cnt_r;

  always_comb begin
    wr_nxt = wr_r + PTR_BITS'(push.n);
    rd_nxt = pop ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r + COUNT_BITS'(push.n) - COUNT_BITS'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r <= '0;
      rd_r <= '0;
      cnt_r <= '0;
    end else begin
      wr_r <= wr_nxt;
      rd_r <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      q_r[wr_r] <= push.r0;
    end
    if (push.n == 2'd2) begin
      q_r[wr1] <= push.r1;
    end
  end

endmodule

/* rtl/expression_token_scanner_top.sv */
// expression token scanner
// input channel: in_valid / in_stall / in_data carry one character byte per
// transfer, or the end-of-input mark (opcode set). result channel: out_valid /
// out_stall / out_data carry one token per transfer: kind, start offset, span,
// negative flag, and last on the final token caused by an input transfer.
// an input transfer is registered and scanned in the next cycle; its tokens
// are written into the result queue, and the first shows on out_data once the
// tokens ahead of it in the queue have transferred.
// throughput is one character per cycle while in_stall is low; a character
// can yield zero, one or two tokens and the end mark one or two, so the
// four-entry result queue decides the rate: in_stall rises when the queue
// could not take two more tokens, and out_stall holds the head token steady.
// an end mark flushes the pending token, sends END and returns the scanner
// to its reset state, which also clears the halt after a bad character.
// reset (rst_n low, synchronous) empties the queue and clears scanner state;
// no clearing pass is needed.
module expression_token_scanner_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ets_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output ets_pkg::out_item_t out_data
);
  import ets_pkg::*;

  push_t                 push;
  logic [COUNT_BITS-1:0] count;
  logic                  in_fire;
  logic                  pop;
  logic [COUNT_BITS:0]   need;

  assign need = {1'b0, count} + (COUNT_BITS + 1)'(push.n);
  assign in_stall = need > (COUNT_BITS + 1)'(QUEUE_DEPTH - 2);
  assign in_fire = in_valid && !in_stall;
  assign pop = out_valid && !out_stall;

  ets_scan u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .in_item (in_data),
    .push    (push)
  );

  ets_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .pop     (pop),
    .rd_vld  (out_valid),
    .rd_item (out_data),
    .count   (count)
  );

endmodule

/* rtl/ets_checker.sv */
module ets_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input ets_pkg::out_item_t out_data
);
  import ets_pkg::*;

  // stalled result transfer holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_end_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind == K_END |->
      out_data.span == 16'd0 && !out_data.negative && out_data.last)
    else $error("malformed END result");

  a_neg_number: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.negative |-> out_data.kind == K_NUMBER)
    else $error("negative flag on non-number");

  a_empty_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_valid && !in_stall)
    else $error("result or stall right after reset");

endmodule

bind expression_token_scanner_top ets_checker u_ets_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
